>>> rtl/core/pbpg_pkg.sv
// Package: constants and types for the pulse burst pattern generator.
`default_nettype none

package pbpg_pkg;

    localparam int unsigned TIME_WIDTH = 32;
    localparam int unsigned STEP_WIDTH = 9;
    localparam int unsigned LOOP_WIDTH = 8;
    localparam int unsigned CFG_WIDTH  = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [LOOP_WIDTH-1:0] INFINITE_COUNT = 8'd255;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_SET   = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ON_TIME    = 2'd0,
        REG_OFF_TIME   = 2'd1,
        REG_PAUSE_TIME = 2'd2,
        REG_TONES      = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> rtl/core/pulse_burst_pattern_generator_top.sv
// Top level: pulse burst pattern generator with registered input and result stages.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item per transfer:
//   mode (tick, start, set, none), now_ms, loop_count and level.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result
//   per input item: the pin level and the active flag after that item.
//   Configuration (on, off, pause time, tones per burst) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_wdata while no item is in flight.
//   Path: the input register, then the state update and result register;
//   o_out_valid rises once the result register is loaded.
//   Throughput: one item per cycle while the receiver does not stall; the
//   state update is a single 32-bit subtract-and-compare plus step counter logic.
//   Reset (i_rst_n low, synchronous) clears configuration, pattern state,
//   pin level and both stage valid flags.
//   When the receiver stalls, the result register holds; one more item can
//   sit in the input register, after which o_in_stall rises.
`default_nettype none

module pulse_burst_pattern_generator_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [pbpg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [pbpg_pkg::CFG_WIDTH-1:0]      i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output      logic                                o_in_stall,
    input  wire logic [1:0]                          i_mode,
    input  wire logic [pbpg_pkg::TIME_WIDTH-1:0]     i_now_ms,
    input  wire logic [pbpg_pkg::LOOP_WIDTH-1:0]     i_loop_count,
    input  wire logic                                i_level,
    output      logic                                o_out_valid,
    input  wire logic                                i_out_stall,
    output      logic                                o_pin_level,
    output      logic                                o_active
);

    localparam int unsigned TW = pbpg_pkg::TIME_WIDTH;
    localparam int unsigned SW = pbpg_pkg::STEP_WIDTH;
    localparam int unsigned LW = pbpg_pkg::LOOP_WIDTH;

    // configuration
    logic [15:0]   r_on_time;
    logic [15:0]   r_off_time;
    logic [15:0]   r_pause_time;
    logic [7:0]    r_tones;

    // input stage
    logic          r_in_valid;
    logic [1:0]    r_mode;
    logic [TW-1:0] r_now;
    logic [LW-1:0] r_count;
    logic          r_level;

    // pattern state
    logic [SW-1:0] r_step_index, n_step_index;
    logic [SW-1:0] r_step_total, n_step_total;
    logic [LW-1:0] r_loops_left, n_loops_left;
    logic [TW-1:0] r_last_time,  n_last_time;
    logic          r_pin,        n_pin;

    // result stage
    logic          r_out_valid;
    logic          r_out_pin;
    logic          r_out_active;

    logic          advance;
    logic          in_take;

    logic [TW-1:0] elapsed;
    logic [15:0]   delay;
    logic [SW:0]   idx_p1_wide;
    logic [SW:0]   total_wide;
    logic          idx_before_last;
    logic [SW-1:0] idx_inc;
    logic [LW-1:0] loops_dec;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take    = !r_in_valid || advance;
    assign o_in_stall = !in_take;

    assign o_out_valid = r_out_valid;
    assign o_pin_level = r_out_pin;
    assign o_active    = r_out_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_time    <= '0;
            r_off_time   <= '0;
            r_pause_time <= '0;
            r_tones      <= '0;
        end else if (i_cfg_we) begin
            unique case (pbpg_pkg::t_cfg_idx'(i_cfg_idx))
                pbpg_pkg::REG_ON_TIME:    r_on_time    <= i_cfg_wdata;
                pbpg_pkg::REG_OFF_TIME:   r_off_time   <= i_cfg_wdata;
                pbpg_pkg::REG_PAUSE_TIME: r_pause_time <= i_cfg_wdata;
                pbpg_pkg::REG_TONES:      r_tones      <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_mode  <= i_mode;
            r_now   <= i_now_ms;
            r_count <= i_loop_count;
            r_level <= i_level;
        end
    end

    // step bookkeeping
    assign idx_p1_wide     = {1'b0, r_step_index} + 1'b1;
    assign total_wide      = {1'b0, r_step_total};
    assign idx_before_last = idx_p1_wide < total_wide;
    assign elapsed         = r_now - r_last_time;
    assign idx_inc         = r_step_index + 1'b1;
    assign loops_dec       = r_loops_left - 1'b1;

    always_comb begin
        if (r_step_index == '0) begin
            delay = r_on_time;
        end else if (idx_before_last) begin
            delay = r_step_index[0] ? r_off_time : r_on_time;
        end else begin
            delay = r_pause_time;
        end
    end

    always_comb begin
        logic [SW-1:0] idx;
        logic [LW-1:0] loops;
        n_step_index = r_step_index;
        n_step_total = r_step_total;
        n_loops_left = r_loops_left;
        n_last_time  = r_last_time;
        n_pin        = r_pin;
        idx          = idx_inc;
        loops        = r_loops_left;
        unique case (pbpg_pkg::t_mode'(r_mode))
            pbpg_pkg::MODE_TICK: begin
                if (r_loops_left != '0 && elapsed >= {{(TW-16){1'b0}}, delay}) begin
                    if (idx == r_step_total) begin
                        if (r_loops_left < pbpg_pkg::INFINITE_COUNT) begin
                            loops = loops_dec;
                        end
                        idx = '0;
                    end
                    if (loops != '0) begin
                        n_pin = ~r_pin;
                    end
                    if (loops == LW'(1) &&
                        ({1'b0, idx} + 1'b1) == total_wide) begin
                        loops = '0;
                        idx   = '0;
                    end
                    n_step_index = idx;
                    n_loops_left = loops;
                    n_last_time  = r_now;
                end
            end
            pbpg_pkg::MODE_START: begin
                n_step_total = (r_tones != '0) ? {r_tones, 1'b0} : SW'(1);
                n_loops_left = r_count;
                n_step_index = '0;
                n_pin        = 1'b1;
                n_last_time  = r_now;
            end
            pbpg_pkg::MODE_SET: begin
                n_step_total = '0;
                n_step_index = '0;
                n_loops_left = '0;
                n_pin        = r_level;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_index <= '0;
            r_step_total <= '0;
            r_loops_left <= '0;
            r_last_time  <= '0;
            r_pin        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_pin    <= 1'b0;
            r_out_active <= 1'b0;
        end else begin
            if (advance) begin
                r_step_index <= n_step_index;
                r_step_total <= n_step_total;
                r_loops_left <= n_loops_left;
                r_last_time  <= n_last_time;
                r_pin        <= n_pin;
                r_out_pin    <= n_pin;
                r_out_active <= (n_loops_left != '0);
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
